### sv/spo_pkg.sv
// Shared types, codes and constants of the stream pool.
package spo_pkg;

  localparam int STREAM_CAP_DEF    = 64;
  localparam int OWNER_ENTRIES_DEF = 64;
  localparam int FREE_DEPTH_DEF    = 128;
  localparam int KEY_BITS_DEF      = 32;

  // Widest values the parameter ranges allow, used for control structs.
  localparam int STREAM_W_MAX    = 8;
  localparam int OWNER_IDX_W_MAX = 10;
  localparam int FREE_CNT_W_MAX  = 12;

  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 3;
  localparam int CNT_W       = 7;
  localparam int ACTOR_W     = 32;
  localparam int STREAM_ID_W = 6;
  localparam int AVAIL_W     = 8;

  localparam logic [CNT_W-1:0] MAX_STREAMS_RST  = 7'd16;
  localparam logic [CNT_W-1:0] INIT_STREAMS_RST = 7'd0;
  localparam logic [CNT_W-1:0] IN_USE_MAX       = 7'd127;

  localparam logic REG_MAX_STREAMS  = 1'b0;
  localparam logic REG_INIT_STREAMS = 1'b1;

  typedef enum logic {
    CMD_LOOKUP  = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_FOUND      = 3'd0,
    STAT_FROM_FREE  = 3'd1,
    STAT_CREATED    = 3'd2,
    STAT_SHARED     = 3'd3,
    STAT_RELEASED   = 3'd4,
    STAT_UNKNOWN    = 3'd5,
    STAT_NO_STREAM  = 3'd6,
    STAT_TABLE_FULL = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_RESOLVE
  } fsm_e;

  typedef struct packed {
    logic             reinit;
    logic [CNT_W-1:0] max_streams;
    logic [CNT_W-1:0] initial_streams;
  } cfg_t;

  typedef struct packed {
    logic                       done;
    logic                       hit;
    logic [OWNER_IDX_W_MAX-1:0] hit_idx;
    logic [STREAM_W_MAX-1:0]    hit_stream;
    logic                       empty;
    logic [OWNER_IDX_W_MAX-1:0] empty_idx;
  } scan_t;

  typedef struct packed {
    logic                       we;
    logic                       set_valid;
    logic [OWNER_IDX_W_MAX-1:0] idx;
    logic [STREAM_W_MAX-1:0]    stream;
  } owner_wr_t;

  typedef struct packed {
    logic                    push;
    logic                    pop;
    logic [STREAM_W_MAX-1:0] stream;
  } queue_op_t;

  typedef struct packed {
    logic                      start;
    logic [FREE_CNT_W_MAX-1:0] fill;
  } fill_t;

endpackage

### sv/spo_req_if.sv
// Request channel: command and owner key.
interface spo_req_if;
  logic                             valid;
  logic                             ready;
  logic                             command;
  logic signed [spo_pkg::ACTOR_W-1:0] owner_id;

  modport source (output valid, command, owner_id, input ready);
  modport sink   (input valid, command, owner_id, output ready);
endinterface

### sv/spo_rsp_if.sv
// Response channel: stream number, status and pool counts.
interface spo_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [spo_pkg::STREAM_ID_W-1:0]   stream_id;
  spo_pkg::status_e                  status;
  logic [spo_pkg::CNT_W-1:0]         in_use_count;
  logic [spo_pkg::CNT_W-1:0]         total_count;
  logic [spo_pkg::AVAIL_W-1:0]       available_count;

  modport source (output valid, stream_id, status, in_use_count, total_count, available_count,
                  input ready);
  modport sink   (input valid, stream_id, status, in_use_count, total_count, available_count,
                  output ready);
endinterface

### sv/spo_cfg.sv
// APB register file holding the pool limits.
module spo_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [spo_pkg::ADDR_W-1:0]   paddr,
  input  logic [spo_pkg::DATA_W-1:0]   pwdata,
  output logic [spo_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output spo_pkg::cfg_t                cfg_o
);
  import spo_pkg::*;

  logic [CNT_W-1:0] max_q;
  logic [CNT_W-1:0] init_q;
  logic             reinit_q;
  logic             wr;

  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q    <= MAX_STREAMS_RST;
      init_q   <= INIT_STREAMS_RST;
      reinit_q <= 1'b0;
    end else begin
      reinit_q <= wr;
      if (wr) begin
        if (paddr[ADDR_W-1] == REG_INIT_STREAMS) begin
          init_q <= pwdata[CNT_W-1:0];
        end else begin
          max_q <= pwdata[CNT_W-1:0];
        end
      end
    end
  end

  assign prdata = (paddr[ADDR_W-1] == REG_MAX_STREAMS) ? DATA_W'(max_q) : DATA_W'(init_q);

  // Rebuild the pool in the cycle after a write, with both registers settled.
  assign cfg_o.reinit          = reinit_q;
  assign cfg_o.max_streams     = max_q;
  assign cfg_o.initial_streams = init_q;

endmodule

### sv/spo_owner_table.sv
// Owner table memory with its sequential key search and clearing sweep.
module spo_owner_table #(
  parameter int OWNER_ENTRIES = spo_pkg::OWNER_ENTRIES_DEF,
  parameter int KEY_BITS      = spo_pkg::KEY_BITS_DEF,
  parameter int STREAM_W      = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  clear_i,
  input  logic                  start_i,
  input  logic [KEY_BITS-1:0]   key_i,
  input  spo_pkg::owner_wr_t    wr_i,
  output spo_pkg::scan_t        scan_o,
  output logic                  busy_o
);
  import spo_pkg::*;

  localparam int IW    = (OWNER_ENTRIES > 1) ? $clog2(OWNER_ENTRIES) : 1;
  localparam int AW    = $clog2(OWNER_ENTRIES + 1);
  localparam int EW    = 1 + KEY_BITS + STREAM_W;
  localparam int V_BIT = EW - 1;

  logic [EW-1:0]       mem [OWNER_ENTRIES];
  logic [EW-1:0]       rd_q;
  logic [KEY_BITS-1:0] rd_key;
  logic [STREAM_W-1:0] rd_stream;

  logic [AW-1:0]       addr_q;
  logic                scan_q;
  logic                rvalid_q;
  logic [IW-1:0]       ridx_q;
  logic                empty_q;
  logic [IW-1:0]       empty_idx_q;
  logic [KEY_BITS-1:0] key_q;
  logic                clr_q;
  logic [IW-1:0]       clr_idx_q;

  logic                issue;
  logic                hit_now;
  logic                last;
  logic                done;
  logic                we;
  logic [IW-1:0]       waddr;
  logic [IW-1:0]       raddr;
  logic [EW-1:0]       wdata;

  assign rd_key    = rd_q[KEY_BITS+STREAM_W-1:STREAM_W];
  assign rd_stream = rd_q[STREAM_W-1:0];

  assign raddr   = addr_q[IW-1:0];
  assign hit_now = rvalid_q & rd_q[V_BIT] & (rd_key == key_q);
  assign last    = (ridx_q == IW'(OWNER_ENTRIES - 1));
  assign done    = rvalid_q & (hit_now | last);
  assign issue   = scan_q & (addr_q < AW'(OWNER_ENTRIES)) & ~hit_now;

  // The clearing sweep owns the write port while it runs.
  assign we    = clr_q | wr_i.we;
  assign waddr = clr_q ? clr_idx_q : IW'(wr_i.idx);
  assign wdata = clr_q ? '0 : {wr_i.set_valid, key_q, STREAM_W'(wr_i.stream)};

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (issue) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q    <= 1'b0;
      rvalid_q  <= 1'b0;
      empty_q   <= 1'b0;
      addr_q    <= '0;
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
    end else begin
      if (clear_i) begin
        clr_q     <= 1'b1;
        clr_idx_q <= '0;
      end else if (clr_q) begin
        if (clr_idx_q == IW'(OWNER_ENTRIES - 1)) begin
          clr_q <= 1'b0;
        end else begin
          clr_idx_q <= clr_idx_q + 1'b1;
        end
      end

      if (start_i) begin
        scan_q   <= 1'b1;
        addr_q   <= '0;
        rvalid_q <= 1'b0;
        empty_q  <= 1'b0;
      end else begin
        rvalid_q <= issue;
        if (issue) begin
          addr_q <= addr_q + 1'b1;
        end
        if (done) begin
          scan_q <= 1'b0;
        end
        if (rvalid_q && !rd_q[V_BIT]) begin
          empty_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      key_q <= key_i;
    end
    if (issue) begin
      ridx_q <= raddr;
    end
    // Keep the first free entry only.
    if (rvalid_q && !rd_q[V_BIT] && !empty_q) begin
      empty_idx_q <= ridx_q;
    end
  end

  assign scan_o.done       = done;
  assign scan_o.hit        = hit_now;
  assign scan_o.hit_idx    = OWNER_IDX_W_MAX'(ridx_q);
  assign scan_o.hit_stream = STREAM_W_MAX'(rd_stream);
  assign scan_o.empty      = empty_q | (rvalid_q & ~rd_q[V_BIT]);
  assign scan_o.empty_idx  = empty_q ? OWNER_IDX_W_MAX'(empty_idx_q) : OWNER_IDX_W_MAX'(ridx_q);

  assign busy_o = clr_q;

endmodule

### sv/spo_free_queue.sv
// Free stream queue: circular memory with head, tail, count and a refill sweep.
module spo_free_queue #(
  parameter int FREE_DEPTH = spo_pkg::FREE_DEPTH_DEF,
  parameter int STREAM_W   = 6
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  spo_pkg::fill_t                        fill_i,
  input  spo_pkg::queue_op_t                    op_i,
  output logic [spo_pkg::STREAM_W_MAX-1:0]      head_o,
  output logic [spo_pkg::FREE_CNT_W_MAX-1:0]    count_o,
  output logic                                  busy_o
);
  import spo_pkg::*;

  localparam int PW = $clog2(FREE_DEPTH);
  localparam int CW = $clog2(FREE_DEPTH + 1);

  logic [STREAM_W-1:0] mem [FREE_DEPTH];
  logic [STREAM_W-1:0] head_rd_q;

  logic [PW-1:0] head_q;
  logic [PW-1:0] tail_q;
  logic [CW-1:0] count_q;
  logic          fill_q;
  logic [PW-1:0] fill_idx_q;
  logic [CW-1:0] fill_n_q;

  logic                push_ok;
  logic                we;
  logic [PW-1:0]       waddr;
  logic [STREAM_W-1:0] wdata;

  // Drop a push that would overflow.
  assign push_ok = op_i.push & (count_q != CW'(FREE_DEPTH));

  assign we    = fill_q | push_ok;
  assign waddr = fill_q ? fill_idx_q : tail_q;
  assign wdata = fill_q ? STREAM_W'(fill_idx_q) : STREAM_W'(op_i.stream);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    head_rd_q <= mem[head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
      fill_q     <= 1'b0;
      fill_idx_q <= '0;
      fill_n_q   <= '0;
    end else if (fill_i.start) begin
      head_q     <= '0;
      count_q    <= CW'(fill_i.fill);
      tail_q     <= (fill_i.fill == FREE_CNT_W_MAX'(FREE_DEPTH)) ? '0 : PW'(fill_i.fill);
      fill_q     <= (fill_i.fill != '0);
      fill_idx_q <= '0;
      fill_n_q   <= CW'(fill_i.fill);
    end else begin
      if (fill_q) begin
        if (CW'(fill_idx_q) == fill_n_q - 1'b1) begin
          fill_q <= 1'b0;
        end else begin
          fill_idx_q <= fill_idx_q + 1'b1;
        end
      end
      if (push_ok) begin
        tail_q  <= (tail_q == PW'(FREE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
        count_q <= count_q + 1'b1;
      end else if (op_i.pop) begin
        head_q  <= (head_q == PW'(FREE_DEPTH - 1)) ? '0 : head_q + 1'b1;
        count_q <= count_q - 1'b1;
      end
    end
  end

  assign head_o  = STREAM_W_MAX'(head_rd_q);
  assign count_o = FREE_CNT_W_MAX'(count_q);
  assign busy_o  = fill_q;

endmodule

### sv/stream_pool_with_owner_table.sv
// Stream pool with owner table. Each request word carries a command and an owner
// key; a lookup returns the owner's mapped stream, else, with a free table entry,
// pops the oldest free stream, else numbers a new one below the configured maximum,
// else shares existing streams in round-robin order; a release pushes the stream
// back to the free queue and unmaps the owner. One response word follows every
// request word. The owner table sits in a synchronous memory that is searched one
// entry a cycle and stops at the owner's entry. A response word that the sink still
// holds stalls the next resolve until it is taken. After reset the block takes no
// request while it clears the owner table. After every register write it takes
// none while it clears the owner table and, in parallel, refills the free queue
// with the pre-created streams that fit it (one entry a cycle). Register writes
// are only legal while the block is idle.
module stream_pool_with_owner_table #(
  parameter int STREAM_CAP    = spo_pkg::STREAM_CAP_DEF,
  parameter int OWNER_ENTRIES = spo_pkg::OWNER_ENTRIES_DEF,
  parameter int FREE_DEPTH    = spo_pkg::FREE_DEPTH_DEF,
  parameter int KEY_BITS      = spo_pkg::KEY_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  spo_req_if.sink                      req_i,
  spo_rsp_if.source                    rsp_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [spo_pkg::ADDR_W-1:0]   paddr,
  input  logic [spo_pkg::DATA_W-1:0]   pwdata,
  output logic [spo_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import spo_pkg::*;

  // Stream number, created count and free count widths.
  localparam int SW  = (STREAM_CAP > 1) ? $clog2(STREAM_CAP) : 1;
  localparam int CW  = $clog2(STREAM_CAP + 1);
  localparam int FCW = $clog2(FREE_DEPTH + 1);
  localparam int XW  = FREE_CNT_W_MAX;

  cfg_t      cfg;
  scan_t     scan;
  scan_t     res_q;
  owner_wr_t owner_wr;
  queue_op_t queue_op;
  fill_t     fill;

  logic                      owner_busy;
  logic                      queue_busy;
  logic [STREAM_W_MAX-1:0]   queue_head;
  logic [FREE_CNT_W_MAX-1:0] queue_count;

  fsm_e state_q;
  fsm_e state_d;
  logic accept;
  logic start;
  logic resolve;

  logic [KEY_BITS-1:0] key;
  logic                cmd_q;

  logic [XW-1:0] lim_x;
  logic [XW-1:0] created0_x;
  logic [XW-1:0] fill_x;
  logic [CW-1:0] lim;

  logic [CW-1:0]    created_q;
  logic [CW-1:0]    created_d;
  logic [CNT_W-1:0] handed_q;
  logic [CNT_W-1:0] handed_d;
  logic [SW-1:0]    share_q;
  logic [SW-1:0]    share_d;
  logic [SW-1:0]    share_pick;
  logic [FCW-1:0]   fcount;
  logic [FCW-1:0]   avail;
  logic [SW-1:0]    stream;
  status_e          status;

  logic                   out_valid_q;
  logic [STREAM_ID_W-1:0] out_stream_q;
  status_e                out_status_q;
  logic [CNT_W-1:0]       out_in_use_q;
  logic [CNT_W-1:0]       out_total_q;
  logic [AVAIL_W-1:0]     out_avail_q;

  spo_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Limits of the pool: the maximum capped at the stream capacity, the
  // pre-created streams capped at that, and what of them fits the queue.
  assign lim_x      = (XW'(cfg.max_streams) > XW'(STREAM_CAP)) ? XW'(STREAM_CAP)
                                                               : XW'(cfg.max_streams);
  assign created0_x = (XW'(cfg.initial_streams) > lim_x) ? lim_x : XW'(cfg.initial_streams);
  assign fill_x     = (created0_x > XW'(FREE_DEPTH)) ? XW'(FREE_DEPTH) : created0_x;
  assign lim        = CW'(lim_x);

  assign fill.start = cfg.reinit;
  assign fill.fill  = fill_x;

  // Only the low KEY_BITS of the owner key take part in the match.
  assign key = KEY_BITS'($unsigned(req_i.owner_id));

  spo_owner_table #(
    .OWNER_ENTRIES (OWNER_ENTRIES),
    .KEY_BITS      (KEY_BITS),
    .STREAM_W      (SW)
  ) u_owner_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (cfg.reinit),
    .start_i (start),
    .key_i   (key),
    .wr_i    (owner_wr),
    .scan_o  (scan),
    .busy_o  (owner_busy)
  );

  spo_free_queue #(
    .FREE_DEPTH (FREE_DEPTH),
    .STREAM_W   (SW)
  ) u_free_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fill_i  (fill),
    .op_i    (queue_op),
    .head_o  (queue_head),
    .count_o (queue_count),
    .busy_o  (queue_busy)
  );

  // Take a request word only with nothing in flight and no sweep running.
  assign req_i.ready = (state_q == FSM_IDLE) & ~owner_busy & ~queue_busy & ~cfg.reinit;
  assign accept      = req_i.valid & req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Search, then resolve once the response register has room.
  always_comb begin
    state_d = state_q;
    start   = 1'b0;
    resolve = 1'b0;
    case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          start   = 1'b1;
          state_d = FSM_SCAN;
        end
      end
      FSM_SCAN: begin
        if (scan.done) begin
          state_d = FSM_RESOLVE;
        end
      end
      FSM_RESOLVE: begin
        if (!out_valid_q || rsp_o.ready) begin
          resolve = 1'b1;
          state_d = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= req_i.command;
    end
    if (state_q == FSM_SCAN && scan.done) begin
      res_q <= scan;
    end
  end

  // A stale share pointer restarts at stream zero.
  assign share_pick = (CW'(share_q) >= created_q) ? '0 : share_q;
  assign fcount     = FCW'(queue_count);

  // Decide the outcome from the search result and the pool state.
  always_comb begin
    status    = STAT_NO_STREAM;
    stream    = '0;
    queue_op  = '0;
    owner_wr  = '0;
    created_d = created_q;
    handed_d  = handed_q;
    share_d   = share_q;
    avail     = fcount;
    if (cmd_q == CMD_LOOKUP) begin
      if (res_q.hit) begin
        status = STAT_FOUND;
        stream = SW'(res_q.hit_stream);
      end else if (!res_q.empty) begin
        status = STAT_TABLE_FULL;
      end else begin
        if (fcount != '0) begin
          status       = STAT_FROM_FREE;
          stream       = SW'(queue_head);
          queue_op.pop = 1'b1;
          avail        = fcount - 1'b1;
        end else if (created_q < lim) begin
          status    = STAT_CREATED;
          stream    = SW'(created_q);
          created_d = created_q + 1'b1;
        end else if (created_q != '0) begin
          status  = STAT_SHARED;
          stream  = share_pick;
          share_d = ((CW'(share_pick) + 1'b1) == created_q) ? '0 : share_pick + 1'b1;
        end else begin
          status = STAT_NO_STREAM;
        end
        if (status != STAT_NO_STREAM) begin
          if (handed_q != IN_USE_MAX) begin
            handed_d = handed_q + 1'b1;
          end
          owner_wr.we        = 1'b1;
          owner_wr.set_valid = 1'b1;
          owner_wr.idx       = res_q.empty_idx;
          owner_wr.stream    = STREAM_W_MAX'(stream);
        end
      end
    end else begin
      if (res_q.hit) begin
        status          = STAT_RELEASED;
        stream          = SW'(res_q.hit_stream);
        queue_op.push   = 1'b1;
        queue_op.stream = STREAM_W_MAX'(stream);
        // A full queue drops the stream.
        if (fcount != FCW'(FREE_DEPTH)) begin
          avail = fcount + 1'b1;
        end
        if (handed_q != '0) begin
          handed_d = handed_q - 1'b1;
        end
        owner_wr.we        = 1'b1;
        owner_wr.set_valid = 1'b0;
        owner_wr.idx       = res_q.hit_idx;
      end else begin
        status = STAT_UNKNOWN;
      end
    end
    if (!resolve) begin
      queue_op = '0;
      owner_wr = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      created_q   <= '0;
      handed_q    <= '0;
      share_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg.reinit) begin
        created_q <= CW'(created0_x);
        handed_q  <= '0;
        share_q   <= '0;
      end else if (resolve) begin
        created_q <= created_d;
        handed_q  <= handed_d;
        share_q   <= share_d;
      end
      if (resolve) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the response word until the sink takes it.
  always_ff @(posedge clk_i) begin
    if (resolve) begin
      out_stream_q <= STREAM_ID_W'(stream);
      out_status_q <= status;
      out_in_use_q <= handed_d;
      out_total_q  <= CNT_W'(created_d);
      out_avail_q  <= AVAIL_W'(avail);
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.stream_id       = out_stream_q;
  assign rsp_o.status          = out_status_q;
  assign rsp_o.in_use_count    = out_in_use_q;
  assign rsp_o.total_count     = out_total_q;
  assign rsp_o.available_count = out_avail_q;

endmodule
